>>> rtl/cdq_pkg.sv
// Package for the circular deque unit: word width, operation and status codes,
// cell action codes and the control word handed to every storage cell.
// No dependencies.
package cdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_WIDTH    = 32;
   localparam int OCC_WIDTH     = 5;

   localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [1:0] OP_PUSH_REAR  = 2'd1;
   localparam logic [1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [1:0] OP_POP_REAR   = 2'd3;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam logic [1:0] CELL_HOLD  = 2'd0;
   localparam logic [1:0] CELL_SHR   = 2'd1;
   localparam logic [1:0] CELL_SHL   = 2'd2;
   localparam logic [1:0] CELL_LOAD  = 2'd3;

   typedef struct packed {
      logic [1:0]            action;
      logic [WORD_WIDTH-1:0] word;
   } cell_ctl_type;

endpackage

>>> rtl/cdq_cell.sv
// One storage cell of the deque chain: holds one word, takes a neighbor's word
// on a shift, loads the pushed word when it is the first free slot.
// Depends on cdq_pkg.
module cdq_cell #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
   parameter int INDEX = 0
) (
   input  logic                                 clock,
   input  cdq_pkg::cell_ctl_type                ctl,
   input  logic [$clog2(DEPTH+1)-1:0]           count,
   input  logic [cdq_pkg::WORD_WIDTH-1:0]       left_word,
   input  logic [cdq_pkg::WORD_WIDTH-1:0]       right_word,
   input  logic [cdq_pkg::WORD_WIDTH-1:0]       rear_in,
   output logic [cdq_pkg::WORD_WIDTH-1:0]       rear_out,
   output logic [cdq_pkg::WORD_WIDTH-1:0]       word_out
);

   localparam int CountWidth = $clog2(DEPTH+1);

   logic [cdq_pkg::WORD_WIDTH-1:0] word_ff;
   logic [cdq_pkg::WORD_WIDTH-1:0] word_in;
   logic                           is_free;
   logic                           is_rear;

   assign is_free = (count == CountWidth'(INDEX));
   assign is_rear = (count == CountWidth'(INDEX + 1));

   always_comb begin
      case (ctl.action)
         cdq_pkg::CELL_SHR:  word_in = left_word;
         cdq_pkg::CELL_SHL:  word_in = right_word;
         cdq_pkg::CELL_LOAD: word_in = is_free ? ctl.word : word_ff;
         default:            word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign rear_out = rear_in | (is_rear ? word_ff : '0);
   assign word_out = word_ff;

endmodule

>>> rtl/circular_deque_unit.sv
// Top level of the circular deque unit: occupancy control, the chain of
// storage cells and the result register. Depends on cdq_pkg and cdq_cell.
//
//  channel  ports                                      direction
//  request  start, busy, req_func, req_push_value     in (busy out)
//  result   rsp_valid, rsp_pop_value, rsp_status,      out
//           rsp_occupancy
//
// One word per cycle: an operation accepted at an edge has its result on the
// rsp_ ports in the next cycle, for that one cycle. busy stays low; the cell
// chain shifts or loads in the same cycle as the occupancy update.
// Reset clears the occupancy and the result strobe; cell contents are undefined.
// The receiver cannot stall; every result is taken in the cycle it shows.
module circular_deque_unit #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_func,
   input  logic signed [cdq_pkg::WORD_WIDTH-1:0] req_push_value,
   output logic                                  rsp_valid,
   output logic signed [cdq_pkg::WORD_WIDTH-1:0] rsp_pop_value,
   output logic [1:0]                            rsp_status,
   output logic [cdq_pkg::OCC_WIDTH-1:0]         rsp_occupancy
);

   localparam int CountWidth = $clog2(DEPTH+1);
   localparam int W          = cdq_pkg::WORD_WIDTH;

   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   rsp_valid_ff;
   logic [W-1:0]           rsp_pop_value_ff, rsp_pop_value_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [cdq_pkg::OCC_WIDTH-1:0] rsp_occupancy_ff;
   logic [CountWidth+cdq_pkg::OCC_WIDTH-1:0] occ_ext;

   logic                   accept;
   logic                   is_full;
   logic                   is_empty;
   cdq_pkg::cell_ctl_type  ctl;

   logic [W-1:0]           cell_word [DEPTH];
   logic [W-1:0]           rear_chain [DEPTH+1];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff == CountWidth'(DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      ctl.word         = req_push_value;
      ctl.action       = cdq_pkg::CELL_HOLD;
      count_in         = count_ff;
      rsp_status_in    = cdq_pkg::ST_DONE;
      rsp_pop_value_in = '0;
      if (accept) begin
         unique case (req_func)
            cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
               if (is_full) begin
                  rsp_status_in = cdq_pkg::ST_FULL;
               end else begin
                  ctl.action = (req_func == cdq_pkg::OP_PUSH_FRONT) ?
                               cdq_pkg::CELL_SHR : cdq_pkg::CELL_LOAD;
                  count_in   = count_ff + CountWidth'(1);
               end
            end
            cdq_pkg::OP_POP_FRONT: begin
               if (is_empty) begin
                  rsp_status_in = cdq_pkg::ST_EMPTY;
               end else begin
                  ctl.action       = cdq_pkg::CELL_SHL;
                  rsp_pop_value_in = cell_word[0];
                  count_in         = count_ff - CountWidth'(1);
               end
            end
            default: begin
               if (is_empty) begin
                  rsp_status_in = cdq_pkg::ST_EMPTY;
               end else begin
                  rsp_pop_value_in = rear_chain[DEPTH];
                  count_in         = count_ff - CountWidth'(1);
               end
            end
         endcase
      end
   end

   assign rear_chain[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [W-1:0] left_word;
      logic [W-1:0] right_word;
      if (i == 0) begin : g_first
         assign left_word = req_push_value;
      end else begin : g_mid_l
         assign left_word = cell_word[i-1];
      end
      if (i == DEPTH-1) begin : g_last
         assign right_word = cell_word[i];
      end else begin : g_mid_r
         assign right_word = cell_word[i+1];
      end
      cdq_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .left_word  (left_word),
         .right_word (right_word),
         .rear_in    (rear_chain[i]),
         .rear_out   (rear_chain[i+1]),
         .word_out   (cell_word[i])
      );
   end

   assign occ_ext = {{cdq_pkg::OCC_WIDTH{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
      rsp_pop_value_ff <= rsp_pop_value_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_occupancy_ff <= occ_ext[cdq_pkg::OCC_WIDTH-1:0];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_value = rsp_pop_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(DEPTH))
      else $error("occupancy above depth");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("missing result strobe");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cdq_pkg::ST_DONE |-> $stable(count_ff))
      else $error("rejected operation changed occupancy");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cdq_pkg::ST_DONE |-> rsp_pop_value == '0)
      else $error("rejected operation returned a word");

endmodule

>>> sim/circular_deque_checker.sv
`timescale 1ns / 1ps
// Checker for the circular deque unit: watches the request and result ports, keeps
// its own ring model of the deque, and counts mismatched or unexpected result words.
// Depends on cdq_pkg.
module circular_deque_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic [1:0]                            req_func,
   input  logic signed [cdq_pkg::WORD_WIDTH-1:0] req_push_value,
   input  logic                                  rsp_valid,
   input  logic signed [cdq_pkg::WORD_WIDTH-1:0] rsp_pop_value,
   input  logic [1:0]                            rsp_status,
   input  logic [cdq_pkg::OCC_WIDTH-1:0]         rsp_occupancy,
   output int                                    error_count,
   output int                                    words_pending
);
   import cdq_pkg::*;

   localparam int SLOTS = DEPTH_DEFAULT;

   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] pop_value;
      logic [1:0]                   status;
      logic [OCC_WIDTH-1:0]         occupancy;
   } deque_result_t;

   logic signed [WORD_WIDTH-1:0] ring_words [SLOTS];
   int                           front_slot;
   int                           back_slot;
   int                           fill_level;
   deque_result_t                pending_results [$];
   int                           mismatches;

   function automatic deque_result_t apply_deque_op(input logic [1:0] func,
                                                    input logic signed [WORD_WIDTH-1:0] word);
      deque_result_t r;
      r.pop_value = '0;
      r.status    = ST_DONE;
      if (func == OP_PUSH_FRONT || func == OP_PUSH_REAR) begin
         if (fill_level >= SLOTS) begin
            r.status = ST_FULL;
         end else if (func == OP_PUSH_FRONT) begin
            front_slot = (front_slot + SLOTS - 1) % SLOTS;
            ring_words[front_slot] = word;
            fill_level++;
         end else begin
            ring_words[back_slot] = word;
            back_slot = (back_slot + 1) % SLOTS;
            fill_level++;
         end
      end else begin
         if (fill_level == 0) begin
            r.status = ST_EMPTY;
         end else if (func == OP_POP_FRONT) begin
            r.pop_value = ring_words[front_slot];
            front_slot = (front_slot + 1) % SLOTS;
            fill_level--;
         end else begin
            back_slot = (back_slot + SLOTS - 1) % SLOTS;
            r.pop_value = ring_words[back_slot];
            fill_level--;
         end
      end
      r.occupancy = fill_level[OCC_WIDTH-1:0];
      return r;
   endfunction

   initial begin
      mismatches    = 0;
      error_count   = 0;
      words_pending = 0;
      front_slot    = 0;
      back_slot     = 0;
      fill_level    = 0;
   end

   always @(posedge clock) begin
      deque_result_t want;
      if (reset) begin
         front_slot = 0;
         back_slot  = 0;
         fill_level = 0;
         pending_results.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected result word pop=%0d status=%0d occ=%0d",
                           $realtime, rsp_pop_value, rsp_status, rsp_occupancy);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_pop_value !== want.pop_value || rsp_status !== want.status ||
                   rsp_occupancy !== want.occupancy) begin
                  if (mismatches < 10)
                     $display("%0t: result mismatch: expected pop=%0d status=%0d occ=%0d, got pop=%0d status=%0d occ=%0d",
                              $realtime, want.pop_value, want.status, want.occupancy,
                              rsp_pop_value, rsp_status, rsp_occupancy);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            pending_results.push_back(apply_deque_op(req_func, req_push_value));
      end
      error_count   <= mismatches;
      words_pending <= pending_results.size();
   end

endmodule

>>> sim/circular_deque_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the circular deque unit: clock, reset, directed and random
// operation words, and the verdict.
// Depends on cdq_pkg, circular_deque_unit, circular_deque_checker.
module circular_deque_unit_test;
   import cdq_pkg::*;

   localparam int RANDOM_WORDS = 1325;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [1:0]                   req_func;
   logic signed [WORD_WIDTH-1:0] req_push_value;
   logic                         rsp_valid;
   logic signed [WORD_WIDTH-1:0] rsp_pop_value;
   logic [1:0]                   rsp_status;
   logic [OCC_WIDTH-1:0]         rsp_occupancy;
   int                           error_count;
   int                           words_pending;

   circular_deque_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy)
   );

   circular_deque_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy),
      .error_count    (error_count),
      .words_pending  (words_pending)
   );

   always #10 clock = ~clock;

   task automatic send_word(input logic [1:0] func, input logic signed [WORD_WIDTH-1:0] value);
      @(negedge clock);
      start          <= 1'b1;
      req_func       <= func;
      req_push_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_idle(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   initial begin
      #2ms;
      $display("circular_deque_unit test failed");
      $finish;
   end

   initial begin
      int         push_pct;
      logic [1:0] func;
      clock          = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_func       = OP_PUSH_FRONT;
      req_push_value = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty pops, extremes in and out, fill to full, rejected pushes
      send_word(OP_POP_FRONT, 32'sh7FFF_FFFF);
      send_word(OP_POP_REAR, -32'sd1);
      send_word(OP_PUSH_FRONT, 32'sh8000_0000);
      send_word(OP_PUSH_REAR, 32'sh7FFF_FFFF);
      send_word(OP_POP_FRONT, 32'sd0);
      send_word(OP_POP_REAR, 32'sd0);
      for (int i = 0; i < DEPTH_DEFAULT; i++)
         send_word(i[0] ? OP_PUSH_REAR : OP_PUSH_FRONT,
                   (i % 4 == 0) ? 32'sh8000_0000 : (i % 4 == 1) ? 32'sh7FFF_FFFF :
                   (i % 4 == 2) ? -32'sd1 : 32'sd0);
      send_word(OP_PUSH_FRONT, 32'sh5555_5555);
      send_word(OP_PUSH_REAR, 32'shAAAA_AAAA);
      send_word(OP_POP_REAR, 32'sd0);
      send_word(OP_POP_FRONT, 32'sd0);

      push_pct = 50;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 32 == 0)
            case ($urandom_range(2))
               0: push_pct = 85;
               1: push_pct = 15;
               default: push_pct = 50;
            endcase
         if ($urandom_range(99) < push_pct)
            func = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
         else
            func = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
         send_word(func, $urandom);
         if (n == 900) begin
            hold_idle(1);
            wait (words_pending == 0);
         end else if ((n < 400 || n >= 700) && $urandom_range(99) < 7) begin
            hold_idle($urandom_range(1, 3));
         end
      end
      hold_idle(1);
      wait (words_pending == 0);
      repeat (5) @(posedge clock);

      if (error_count == 0 && words_pending == 0)
         $display("circular_deque_unit test passed");
      else
         $display("circular_deque_unit test failed");
      $finish;
   end

endmodule

>>> circular_deque_unit.f
rtl/cdq_pkg.sv
rtl/cdq_cell.sv
rtl/circular_deque_unit.sv
sim/circular_deque_checker.sv
sim/circular_deque_unit_test.sv
